// ===== rtl/core/mtb_pkg.sv =====
// ----------------------------------------------------------------------------
// mtb_pkg: shared types and constants of the bounded MT19937-64 generator
// Request and result layouts, request codes and the generator constants.
// ----------------------------------------------------------------------------
package mtb_pkg;

    localparam int STATE_WORDS_DEF   = 312;
    localparam int MIDDLE_OFFSET_DEF = 156;

    localparam logic [63:0] SEED_RESET  = 64'd5489;
    localparam logic [63:0] TW_MATRIX   = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TW_UPPER    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] TW_LOWER    = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] TW_SEED_MUL = 64'd6364136223846793005;
    localparam logic [63:0] TEMPER_B    = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_C    = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_D    = 64'hFFF7_EEE0_0000_0000;

    localparam logic [1:0] FUNC_RESEED = 2'd0;
    localparam logic [1:0] FUNC_RAW    = 2'd1;
    localparam logic [1:0] FUNC_RANGE  = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [63:0]         seed_value;
        logic signed [63:0]  range_low;
        logic signed [63:0]  range_high;
    } request_t;

    typedef struct packed {
        logic signed [63:0]  value;
        logic                status;
    } result_t;

endpackage

// ===== rtl/core/mtb_ram.sv =====
// ----------------------------------------------------------------------------
// mtb_ram: state word memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mtb_ram #(
    parameter int DEPTH = mtb_pkg::STATE_WORDS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [63:0]       wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [63:0]       rdata_a,
    output logic [63:0]       rdata_b
);
    import mtb_pkg::*;

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_a_reg;
    logic [63:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/core/mtb_seeder.sv =====
// ----------------------------------------------------------------------------
// mtb_seeder: state word seeding sequencer
// Writes the seed and then each derived word in the phases low-low, low-high,
// high-low and sum, through one shared 32 by 32 multiplier.
// ----------------------------------------------------------------------------
module mtb_seeder #(
    parameter int DEPTH = mtb_pkg::STATE_WORDS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       seed,
    output logic              done,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output logic [63:0]       wdata
);
    import mtb_pkg::*;

    typedef enum logic {SD_IDLE, SD_MUL} sd_state_t;

    localparam logic [1:0] PH_LL  = 2'd0;
    localparam logic [1:0] PH_LH  = 2'd1;
    localparam logic [1:0] PH_HL  = 2'd2;
    localparam logic [1:0] PH_SUM = 2'd3;

    sd_state_t         state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic              done_reg, done_next;
    logic [63:0]       prev_reg, prev_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       prod_reg, prod_next;
    logic [63:0]       mix;
    logic [63:0]       word;
    logic [31:0]       op_a;
    logic [31:0]       op_b;

    // Low half of mix times the constant is built from three partial products.
    assign mix       = prev_reg ^ (prev_reg >> 62);
    assign op_a      = (phase_reg == PH_HL) ? mix[63:32] : mix[31:0];
    assign op_b      = (phase_reg == PH_LH) ? TW_SEED_MUL[63:32] : TW_SEED_MUL[31:0];
    assign prod_next = 64'(op_a) * 64'(op_b);
    assign word      = acc_reg + {prod_reg[31:0], 32'h0} + 64'(k_reg);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        prev_next  = prev_reg;
        acc_next   = acc_reg;
        case (state_reg)
            SD_IDLE:
            begin
                if (start)
                begin
                    prev_next  = seed;
                    k_next     = ADDR_W'(1);
                    phase_next = PH_LL;
                    state_next = SD_MUL;
                end
            end
            SD_MUL:
            begin
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    PH_LH:
                    begin
                        acc_next = prod_reg;
                    end
                    PH_HL:
                    begin
                        acc_next = acc_reg + {prod_reg[31:0], 32'h0};
                    end
                    PH_SUM:
                    begin
                        prev_next = word;
                        k_next    = k_reg + ADDR_W'(1);
                        if (k_reg == ADDR_W'(DEPTH - 1))
                        begin
                            done_next  = 1'b1;
                            state_next = SD_IDLE;
                        end
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            default:
            begin
                state_next = SD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SD_IDLE;
            phase_reg <= PH_LL;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign we    = ((state_reg == SD_IDLE) && start) ||
                   ((state_reg == SD_MUL) && (phase_reg == PH_SUM));
    assign waddr = (state_reg == SD_MUL) ? k_reg : '0;
    assign wdata = (state_reg == SD_MUL) ? word : seed;
    assign done  = done_reg;

endmodule

// ===== rtl/core/mtb_regen.sv =====
// ----------------------------------------------------------------------------
// mtb_regen: in-place regeneration of the state words
// Streams through the memory one word per cycle: two reads issued, the new
// word written back in the following cycle.
// ----------------------------------------------------------------------------
module mtb_regen #(
    parameter int DEPTH  = mtb_pkg::STATE_WORDS_DEF,
    parameter int MIDDLE = mtb_pkg::MIDDLE_OFFSET_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              done,
    output logic [ADDR_W-1:0] raddr_a,
    output logic [ADDR_W-1:0] raddr_b,
    input  logic [63:0]       rdata_a,
    input  logic [63:0]       rdata_b,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output logic [63:0]       wdata
);
    import mtb_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 2);

    typedef enum logic {RG_IDLE, RG_RUN} rg_state_t;

    rg_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              pv_reg, pv_next;
    logic              pprime_reg, pprime_next;
    logic [ADDR_W-1:0] pk_reg, pk_next;
    logic              done_reg, done_next;
    logic [63:0]       hold_reg, hold_next;
    logic [ADDR_W-1:0] k_iss;
    logic              issuing;

    function automatic logic [63:0] twist_pair(input logic [63:0] hi_word,
                                               input logic [63:0] lo_word,
                                               input logic [63:0] far);
        logic [63:0] y;
        logic [63:0] r;
        y = (hi_word & TW_UPPER) | (lo_word & TW_LOWER);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ TW_MATRIX;
        end
        return r;
    endfunction

    // The first issue slot only fetches word zero, the upper half of step zero.
    assign issuing = (state_reg == RG_RUN) && (iss_reg <= CNT_W'(DEPTH));
    assign k_iss   = ADDR_W'(iss_reg - CNT_W'(1));
    assign raddr_a = ((iss_reg == '0) || (iss_reg == CNT_W'(DEPTH))) ? '0 : ADDR_W'(iss_reg);
    assign raddr_b = (k_iss < ADDR_W'(DEPTH - MIDDLE)) ? k_iss + ADDR_W'(MIDDLE)
                                                       : k_iss - ADDR_W'(DEPTH - MIDDLE);

    assign we    = pv_reg && !pprime_reg;
    assign waddr = pk_reg;
    assign wdata = twist_pair(hold_reg, rdata_a, rdata_b);

    always_comb
    begin
        state_next  = state_reg;
        iss_next    = iss_reg;
        pv_next     = issuing;
        pprime_next = issuing && (iss_reg == '0);
        pk_next     = k_iss;
        done_next   = 1'b0;
        hold_next   = pv_reg ? rdata_a : hold_reg;
        case (state_reg)
            RG_IDLE:
            begin
                if (start)
                begin
                    iss_next   = '0;
                    state_next = RG_RUN;
                end
            end
            RG_RUN:
            begin
                if (issuing)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (we && (pk_reg == ADDR_W'(DEPTH - 1)))
                begin
                    done_next  = 1'b1;
                    state_next = RG_IDLE;
                end
            end
            default:
            begin
                state_next = RG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= RG_IDLE;
            iss_reg    <= '0;
            pv_reg     <= 1'b0;
            pprime_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            pv_reg     <= pv_next;
            pprime_reg <= pprime_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pk_reg   <= pk_next;
        hold_reg <= hold_next;
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/mt19937_64_bounded_random.sv =====
// ----------------------------------------------------------------------------
// mt19937_64_bounded_random: bounded 64-bit MT19937-64 random number block
// Reseed, raw draw and signed range draw with rejection, on one state memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and must be taken then,
// since the receiver cannot stall the block. A draw whose word is ready goes
// through the registered memory read, the combinational tempering step and
// the registered result. Every 312th draw first regenerates the state words
// in place: one memory pass at one word per cycle over the two read ports and
// the single write port. A reseed writes the words one after another through
// the one shared 32 by 32 seeding multiplier. A rejected range draw redraws
// from the next state word, and the first draw after reset seeds from
// default_seed before it regenerates.
module mt19937_64_bounded_random #(
    parameter int STATE_WORDS   = mtb_pkg::STATE_WORDS_DEF,
    parameter int MIDDLE_OFFSET = mtb_pkg::MIDDLE_OFFSET_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mtb_pkg::request_t request,
    output logic              done,
    output mtb_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [63:0]       cfg_wdata
);
    import mtb_pkg::*;

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int IDX_W  = $clog2(STATE_WORDS + 2);

    typedef enum logic [2:0] {T_IDLE, T_SEED, T_REGEN, T_DRAW, T_DATA} top_state_t;

    top_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [63:0]       default_seed_reg;
    request_t          req_reg, req_next;
    logic [63:0]       span_reg, span_next;
    logic [63:0]       mask_reg, mask_next;
    logic              empty_reg, empty_next;

    logic              dispatch;
    logic              seed_start;
    logic              regen_start;
    logic [ADDR_W-1:0] draw_addr;
    logic [63:0]       tempered;
    logic [63:0]       masked;
    logic [63:0]       req_span;
    logic [63:0]       seed_src;

    logic              seed_done, seed_we;
    logic [ADDR_W-1:0] seed_waddr;
    logic [63:0]       seed_wdata;
    logic              regen_done, regen_we;
    logic [ADDR_W-1:0] regen_waddr, regen_raddr_a, regen_raddr_b;
    logic [63:0]       regen_wdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr_a;
    logic [63:0]       mem_wdata, rdata_a, rdata_b;

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] x;
        x = w;
        x = x ^ ((x >> 29) & TEMPER_B);
        x = x ^ ((x << 17) & TEMPER_C);
        x = x ^ ((x << 37) & TEMPER_D);
        x = x ^ (x >> 43);
        return x;
    endfunction

    function automatic logic [63:0] all_ones_cover(input logic [63:0] n);
        logic [63:0] m;
        m = n;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
        return m;
    endfunction

    assign req_span = $unsigned(request.range_high) - $unsigned(request.range_low);
    assign tempered = temper(rdata_a);
    assign masked   = tempered & mask_reg;
    assign seed_src = ((state_reg == T_IDLE) && (request.func == FUNC_RESEED))
                      ? request.seed_value : default_seed_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        req_next    = req_reg;
        span_next   = span_reg;
        mask_next   = mask_reg;
        empty_next  = empty_reg;
        dispatch    = 1'b0;
        seed_start  = 1'b0;
        regen_start = 1'b0;
        draw_addr   = '0;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    span_next  = req_span;
                    mask_next  = all_ones_cover(req_span);
                    empty_next = $signed(request.range_low) > $signed(request.range_high);
                    case (request.func)
                        FUNC_RESEED:
                        begin
                            seed_start = 1'b1;
                            state_next = T_SEED;
                        end
                        FUNC_RAW, FUNC_RANGE:
                        begin
                            dispatch = 1'b1;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end
            T_SEED:
            begin
                if (seed_done)
                begin
                    idx_next = IDX_W'(STATE_WORDS);
                    if (req_reg.func == FUNC_RESEED)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = T_IDLE;
                    end
                    else
                    begin
                        regen_start = 1'b1;
                        state_next  = T_REGEN;
                    end
                end
            end
            T_REGEN:
            begin
                if (regen_done)
                begin
                    idx_next   = '0;
                    state_next = T_DRAW;
                end
            end
            T_DRAW:
            begin
                dispatch = 1'b1;
            end
            T_DATA:
            begin
                case (req_reg.func)
                    FUNC_RAW:
                    begin
                        done_next          = 1'b1;
                        result_next.value  = $signed(tempered);
                        result_next.status = 1'b0;
                        state_next         = T_IDLE;
                    end
                    FUNC_RANGE:
                    begin
                        if (empty_reg)
                        begin
                            done_next          = 1'b1;
                            result_next.value  = '0;
                            result_next.status = 1'b1;
                            state_next         = T_IDLE;
                        end
                        else if (masked > span_reg)
                        begin
                            dispatch = 1'b1;
                        end
                        else
                        begin
                            done_next          = 1'b1;
                            result_next.value  = $signed(masked + $unsigned(req_reg.range_low));
                            result_next.status = 1'b0;
                            state_next         = T_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = T_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase

        if (dispatch)
        begin
            if (idx_reg < IDX_W'(STATE_WORDS))
            begin
                draw_addr  = idx_reg[ADDR_W-1:0];
                idx_next   = idx_reg + IDX_W'(1);
                state_next = T_DATA;
            end
            else if (idx_reg == IDX_W'(STATE_WORDS))
            begin
                regen_start = 1'b1;
                state_next  = T_REGEN;
            end
            else
            begin
                seed_start = 1'b1;
                state_next = T_SEED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            idx_reg    <= IDX_W'(STATE_WORDS + 1);
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_seed_reg <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            default_seed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        span_reg  <= span_next;
        mask_reg  <= mask_next;
        empty_reg <= empty_next;
    end

    assign mem_we      = seed_we | regen_we;
    assign mem_waddr   = seed_we ? seed_waddr : regen_waddr;
    assign mem_wdata   = seed_we ? seed_wdata : regen_wdata;
    assign mem_raddr_a = (state_reg == T_REGEN) ? regen_raddr_a : draw_addr;

    mtb_ram #(
        .DEPTH   (STATE_WORDS)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (regen_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mtb_seeder #(
        .DEPTH (STATE_WORDS)
    ) u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed_src),
        .done  (seed_done),
        .we    (seed_we),
        .waddr (seed_waddr),
        .wdata (seed_wdata)
    );

    mtb_regen #(
        .DEPTH   (STATE_WORDS),
        .MIDDLE  (MIDDLE_OFFSET)
    ) u_regen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (regen_start),
        .done    (regen_done),
        .raddr_a (regen_raddr_a),
        .raddr_b (regen_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .we      (regen_we),
        .waddr   (regen_waddr),
        .wdata   (regen_wdata)
    );

    assign busy   = (state_reg != T_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/mtb_checker.sv =====
// ----------------------------------------------------------------------------
// mtb_checker: port-level checks of the bounded random block
// Relates requests, busy and result strobes over time.
// ----------------------------------------------------------------------------
module mtb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input mtb_pkg::request_t request,
    input logic              done,
    input mtb_pkg::result_t  result
);
    import mtb_pkg::*;

    // A result is only issued as the block returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every result comes from a request taken or worked on in the cycle before.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start || busy))
        else $error("result strobe without a request");

    // A taken request either answers at once or keeps the block busy.
    a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("request dropped");

    // An empty interval reports a zero value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.value == '0))
        else $error("error result with nonzero value");

endmodule

bind mt19937_64_bounded_random mtb_checker u_checker (.*);

// ===== dv/tb_mt19937_64_bounded_random.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mt19937_64_bounded_random: self-checking bench for the bounded MT19937-64
// A short table of directed requests is followed by about 1500 random ones
// over several sender idling phases. Each result is checked against an
// in-bench twister with its own state words or against a value written in:
// the first standard-seed draw, one-value and empty ranges, unused code, reseeds.
// ----------------------------------------------------------------------------
module tb_mt19937_64_bounded_random;

    import mtb_pkg::*;

    localparam logic [1:0]         FUNC_UNUSED    = 2'd3;
    localparam logic signed [63:0] S64_MIN        = {1'b1, 63'd0};
    localparam logic signed [63:0] S64_MAX        = {1'b0, {63{1'b1}}};
    localparam logic [63:0]        STD_FIRST_DRAW = 64'd14514284786278117030;
    localparam int                 WATCHDOG_LIMIT = 20000;
    localparam int                 RANDOM_ITEMS   = 1500;

    typedef struct packed {
        request_t req;
        logic     typed;
        result_t  want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    logic [63:0] mt_words [STATE_WORDS_DEF];
    int          mt_pos;
    logic [63:0] fallback_seed;

    result_t     awaited_results[$];
    row_t        stim_rows[$];

    int n_errors;
    int n_results;
    int n_reseed;
    int n_raw;
    int n_range;
    int n_empty;
    int n_unused;
    int n_redraws;
    int n_refills;
    int n_seed_writes;
    int stall_cycles;

    mt19937_64_bounded_random u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void fill_words(logic [63:0] s);
        logic [63:0] p;
        mt_words[0] = s;
        for (int k = 1; k < STATE_WORDS_DEF; k++)
        begin
            p = mt_words[k - 1];
            mt_words[k] = TW_SEED_MUL * (p ^ (p >> 62)) + 64'(k);
        end
        mt_pos = STATE_WORDS_DEF;
    endfunction

    function automatic logic [63:0] twist(logic [63:0] hi_w, logic [63:0] lo_w,
                                          logic [63:0] far);
        logic [63:0] y;
        logic [63:0] r;
        y = (hi_w & TW_UPPER) | (lo_w & TW_LOWER);
        r = far ^ (y >> 1);
        if (y[0])
            r = r ^ TW_MATRIX;
        return r;
    endfunction

    function automatic void refill_words();
        int k;
        for (k = 0; k < STATE_WORDS_DEF - MIDDLE_OFFSET_DEF; k++)
            mt_words[k] = twist(mt_words[k], mt_words[k + 1],
                                mt_words[k + MIDDLE_OFFSET_DEF]);
        for (; k < STATE_WORDS_DEF - 1; k++)
            mt_words[k] = twist(mt_words[k], mt_words[k + 1],
                                mt_words[k + MIDDLE_OFFSET_DEF - STATE_WORDS_DEF]);
        mt_words[STATE_WORDS_DEF - 1] = twist(mt_words[STATE_WORDS_DEF - 1], mt_words[0],
                                              mt_words[MIDDLE_OFFSET_DEF - 1]);
        mt_pos = 0;
        n_refills++;
    endfunction

    function automatic logic [63:0] next_tempered();
        logic [63:0] x;
        if (mt_pos >= STATE_WORDS_DEF)
        begin
            if (mt_pos > STATE_WORDS_DEF)
                fill_words(fallback_seed);
            refill_words();
        end
        x = mt_words[mt_pos % STATE_WORDS_DEF];
        mt_pos++;
        x = x ^ ((x >> 29) & TEMPER_B);
        x = x ^ ((x << 17) & TEMPER_C);
        x = x ^ ((x << 37) & TEMPER_D);
        x = x ^ (x >> 43);
        return x;
    endfunction

    function automatic logic [63:0] cover_mask(logic [63:0] n);
        n = n | (n >> 1);
        n = n | (n >> 2);
        n = n | (n >> 4);
        n = n | (n >> 8);
        n = n | (n >> 16);
        n = n | (n >> 32);
        return n;
    endfunction

    function automatic result_t twister_result(request_t r);
        result_t     res;
        logic [63:0] word;
        logic [63:0] span;
        logic [63:0] mask;
        res = '0;
        case (r.func)
            FUNC_RESEED: fill_words(r.seed_value);
            FUNC_RAW:    res.value = next_tempered();
            FUNC_RANGE:
            begin
                word = next_tempered();
                if ($signed(r.range_low) > $signed(r.range_high))
                    res.status = 1'b1;
                else
                begin
                    span = r.range_high - r.range_low;
                    mask = cover_mask(span);
                    word = word & mask;
                    while (word > span)
                    begin
                        word = next_tempered() & mask;
                        n_redraws++;
                    end
                    res.value = word + r.range_low;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic request_t random_request();
        request_t    r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] span;
        int          pick;
        int          bits;
        r.seed_value = rand64();
        r.range_low  = rand64();
        r.range_high = rand64();
        pick = $urandom_range(99);
        if (pick < 3)
            r.func = FUNC_RESEED;
        else if (pick < 5)
            r.func = FUNC_UNUSED;
        else if (pick < 35)
            r.func = FUNC_RAW;
        else
        begin
            r.func = FUNC_RANGE;
            case ($urandom_range(9))
                0: ;
                1, 2:
                begin
                    span = 64'($urandom_range(300));
                    r.range_high = r.range_low + span;
                    if ($signed(r.range_high) < $signed(r.range_low))
                    begin
                        r.range_high = S64_MAX;
                        r.range_low  = S64_MAX - span;
                    end
                end
                3:
                begin
                    span = 64'd1 << $urandom_range(62);
                    r.range_low  = 64'd0 - (span >> 1);
                    r.range_high = r.range_low + span;
                end
                4:
                begin
                    span = (64'd1 << $urandom_range(1, 63)) - 64'd1;
                    r.range_low  = 64'd0 - (span >> 1);
                    r.range_high = r.range_low + span;
                end
                5:
                begin
                    r.range_low  = $urandom_range(1) ? S64_MIN : 64'd0;
                    r.range_high = $urandom_range(1) ? S64_MAX : -64'sd1;
                end
                6:
                begin
                    a = rand64();
                    b = rand64();
                    if ($signed(a) > $signed(b))
                    begin
                        r.range_low  = a;
                        r.range_high = b;
                    end
                    else if ($signed(a) < $signed(b))
                    begin
                        r.range_low  = b;
                        r.range_high = a;
                    end
                    else
                    begin
                        r.range_low  = S64_MAX;
                        r.range_high = S64_MIN;
                    end
                end
                7: r.range_high = r.range_low;
                default:
                begin
                    bits = $urandom_range(1, 63);
                    span = rand64() & ((64'd1 << bits) - 64'd1);
                    r.range_low  = 64'd0 - (span >> 1);
                    r.range_high = r.range_low + span;
                end
            endcase
        end
        return r;
    endfunction

    function automatic result_t make_result(logic [63:0] v, logic st);
        result_t res;
        res.value  = v;
        res.status = st;
        return res;
    endfunction

    task automatic add_row(logic [1:0] f, logic [63:0] seed, logic [63:0] lo,
                           logic [63:0] hi, logic typed, logic [63:0] v, logic st);
        row_t row;
        row.req.func       = f;
        row.req.seed_value = seed;
        row.req.range_low  = lo;
        row.req.range_high = hi;
        row.typed          = typed;
        row.want           = make_result(v, st);
        stim_rows.push_back(row);
    endtask

    task automatic note_error(string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("%s", msg);
    endtask

    task automatic issue(request_t r, int idle_pct, logic typed, result_t want);
        result_t predicted;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = twister_result(r);
        awaited_results.push_back(typed ? want : predicted);
        case (r.func)
            FUNC_RESEED: n_reseed++;
            FUNC_RAW:    n_raw++;
            FUNC_RANGE:
            begin
                n_range++;
                if ($signed(r.range_low) > $signed(r.range_high))
                    n_empty++;
            end
            default:     n_unused++;
        endcase
    endtask

    task automatic settle_and_write_seed(logic [63:0] v);
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        fallback_seed = v;
        n_seed_writes++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (awaited_results.size() == 0)
                note_error($sformatf("unexpected result value=%h status=%0b",
                                     result.value, result.status));
            else
            begin
                want = awaited_results.pop_front();
                if (result.value !== want.value)
                    note_error($sformatf("value mismatch: expected %h, got %h",
                                         want.value, result.value));
                if (result.status !== want.status)
                    note_error($sformatf("status mismatch: expected %0b, got %0b",
                                         want.status, result.status));
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: timeout after %0d cycles without a request or result", stall_cycles);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        request_t r;
        row_t     row;
        int       idle_pct;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        n_errors  = 0;
        n_results = 0;
        n_reseed  = 0;
        n_raw     = 0;
        n_range   = 0;
        n_empty   = 0;
        n_unused  = 0;
        n_redraws = 0;
        n_refills = 0;
        n_seed_writes = 0;
        fallback_seed = SEED_RESET;
        mt_pos        = STATE_WORDS_DEF + 1;

        add_row(FUNC_RAW,    '0, '0, '0, 1'b1, STD_FIRST_DRAW, 1'b0);
        add_row(FUNC_RANGE,  '0, -64'sd5, 64'sd5, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, S64_MIN, S64_MIN, 1'b1, S64_MIN, 1'b0);
        add_row(FUNC_RANGE,  '0, S64_MAX, S64_MAX, 1'b1, S64_MAX, 1'b0);
        add_row(FUNC_RANGE,  '0, S64_MIN, S64_MAX, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, S64_MAX, S64_MIN, 1'b1, '0, 1'b1);
        add_row(FUNC_RANGE,  '0, 64'sd0, -64'sd1, 1'b1, '0, 1'b1);
        add_row(FUNC_RANGE,  '0, 64'sd1, 64'sd0, 1'b1, '0, 1'b1);
        add_row(FUNC_UNUSED, '1, '1, '1, 1'b1, '0, 1'b0);
        add_row(FUNC_RESEED, '0, '1, '0, 1'b1, '0, 1'b0);
        add_row(FUNC_RAW,    '1, '0, '1, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, 64'sd0, 64'sd1 << 62, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, -64'sd1, 64'sd0, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, S64_MIN, -64'sd1, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, 64'sd0, S64_MAX, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, -(64'sd1 << 62), 64'sd1 << 62, 1'b0, '0, 1'b0);
        add_row(FUNC_RESEED, '1, '0, '0, 1'b1, '0, 1'b0);
        add_row(FUNC_RAW,    '0, '0, '0, 1'b0, '0, 1'b0);
        add_row(FUNC_RANGE,  '0, S64_MIN, 64'sd0, 1'b0, '0, 1'b0);
        add_row(FUNC_RESEED, SEED_RESET, '0, '0, 1'b1, '0, 1'b0);
        add_row(FUNC_RAW,    '0, '0, '0, 1'b1, STD_FIRST_DRAW, 1'b0);
        add_row(FUNC_RANGE,  '0, 64'sd10, 64'sd10, 1'b1, 64'd10, 1'b0);
        add_row(FUNC_RANGE,  '0, -64'sd1000, 64'sd1000, 1'b0, '0, 1'b0);
        add_row(FUNC_RAW,    '0, '0, '0, 1'b0, '0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            issue(row.req, 0, row.typed, row.want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: settle_and_write_seed('0);
                1: settle_and_write_seed('1);
                default: settle_and_write_seed(rand64());
            endcase
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 66 : 16;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                r = random_request();
                issue(r, idle_pct, 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (awaited_results.size() != 0)
            note_error($sformatf("%0d results never arrived", awaited_results.size()));

        $display("tb: %0d requests: %0d reseeds, %0d raw, %0d range (%0d empty), %0d unused",
                 n_reseed + n_raw + n_range + n_unused, n_reseed, n_raw, n_range, n_empty,
                 n_unused);
        $display("tb: %0d results checked, %0d redraws, %0d state refills, %0d seed writes",
                 n_results, n_redraws, n_refills, n_seed_writes);
        if (n_errors == 0)
            $display("tb: success");
        else
        begin
            $display("tb: %0d errors", n_errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mtb_pkg.sv
rtl/core/mtb_ram.sv
rtl/core/mtb_seeder.sv
rtl/core/mtb_regen.sv
rtl/core/mt19937_64_bounded_random.sv
rtl/core/mtb_checker.sv
dv/tb_mt19937_64_bounded_random.sv
